@@ rtl/taq_pkg.sv @@
// ----------------------------------------------------------------------------
// taq_pkg
// Shared types and constants for the timed action sorted queue: the stored
// entry layout, the command codes and the sequencer states.
// ----------------------------------------------------------------------------
package taq_pkg;

  // Default number of entries the queue holds.
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Field widths fixed by the item layout.
  localparam int unsigned TimeW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CountW = 5;

  // Command codes; the fourth code is unused and changes nothing.
  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  // One stored action.
  typedef struct packed {
    logic [TimeW-1:0] ev_time;
    logic [KindW-1:0] kind;
  } entry_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_CMP,
    ST_ADD_PUT,
    ST_POP_MV,
    ST_DONE
  } state_e;

endpackage : taq_pkg

@@ rtl/taq_store.sv @@
// ----------------------------------------------------------------------------
// taq_store
// Entry storage for the queue: one write port and one read port with
// registered read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module taq_store #(
  parameter int unsigned Depth = taq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  taq_pkg::entry_t   wdata_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  raddr_i,
  output taq_pkg::entry_t   rdata_o
);
  import taq_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : taq_store

@@ rtl/taq_seq.sv @@
// ----------------------------------------------------------------------------
// taq_seq
// Command sequencer for the queue. It walks the storage one entry per cycle
// to open a gap for an add or to close the gap left by a pop, using a single
// shared 32-bit magnitude comparator, and keeps the head entry in a register.
// ----------------------------------------------------------------------------
module taq_seq #(
  parameter int unsigned Depth  = taq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned AddrW  = $clog2(Depth),
  parameter int unsigned CntW   = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Command side.
  input  logic                        start,
  output logic                        busy,
  input  logic [taq_pkg::CmdW-1:0]    cmd_i,
  input  logic [taq_pkg::TimeW-1:0]   event_time_i,
  input  logic [taq_pkg::KindW-1:0]   event_kind_i,
  input  logic [taq_pkg::TimeW-1:0]   now_time_i,
  // Storage port.
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output taq_pkg::entry_t             mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AddrW-1:0]            mem_raddr_o,
  input  taq_pkg::entry_t             mem_rdata_i,
  // Result side.
  output logic                        result_valid_o,
  output logic                        op_ok_o,
  output logic [taq_pkg::TimeW-1:0]   popped_time_o,
  output logic [taq_pkg::KindW-1:0]   popped_kind_o,
  output logic [taq_pkg::CountW-1:0]  entry_count_o,
  output logic                        head_valid_o,
  output logic [taq_pkg::TimeW-1:0]   head_time_o
);
  import taq_pkg::*;

  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [CntW-1:0] OneC   = CntW'(1);
  localparam logic [CntW-1:0] TwoC   = CntW'(2);

  state_e            state_q, state_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   count_q, count_d;
  entry_t            head_q, head_d;
  entry_t            new_q, new_d;
  logic              ok_q, ok_d;
  logic [TimeW-1:0]  ptime_q, ptime_d;
  logic [KindW-1:0]  pkind_q, pkind_d;

  logic              accept;
  logic              due;
  logic [TimeW-1:0]  cmp_a, cmp_b;
  logic              cmp_gt;
  logic [CntW-1:0]   idx_m1, idx_m2, idx_p1, cnt_m1;
  logic [CntW+CountW-1:0] count_wide;

  assign accept = start && !busy;

  // Shared comparator: stored time against the new time while opening a
  // gap, head time against the current time when a pop is accepted.
  always_comb begin
    if (state_q == ST_ADD_CMP) begin
      cmp_a = mem_rdata_i.ev_time;
      cmp_b = new_q.ev_time;
    end else begin
      cmp_a = head_q.ev_time;
      cmp_b = now_time_i;
    end
  end
  assign cmp_gt = cmp_a > cmp_b;
  assign due    = (count_q != '0) && !cmp_gt;

  assign idx_m1 = idx_q - OneC;
  assign idx_m2 = idx_q - TwoC;
  assign idx_p1 = idx_q + OneC;
  assign cnt_m1 = count_q - OneC;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          case (cmd_i)
            CMD_ADD: begin
              if (count_q == DepthC) begin
                state_d = ST_DONE;
              end else if (count_q == '0) begin
                state_d = ST_ADD_PUT;
              end else begin
                state_d = ST_ADD_CMP;
              end
            end
            CMD_POP: begin
              if (due && count_q != OneC) begin
                state_d = ST_POP_MV;
              end else begin
                state_d = ST_DONE;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADD_CMP: begin
        if (cmp_gt && idx_q != OneC) begin
          state_d = ST_ADD_CMP;
        end else begin
          state_d = ST_ADD_PUT;
        end
      end
      ST_ADD_PUT: state_d = ST_DONE;
      ST_POP_MV: begin
        if (idx_p1 < count_q) begin
          state_d = ST_POP_MV;
        end else begin
          state_d = ST_DONE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and storage control.
  always_comb begin
    idx_d       = idx_q;
    count_d     = count_q;
    head_d      = head_q;
    new_d       = new_q;
    ok_d        = ok_q;
    ptime_d     = ptime_q;
    pkind_d     = pkind_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q[AddrW-1:0];
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_m1[AddrW-1:0];
    case (state_q)
      ST_IDLE, ST_DONE: begin
        if (accept) begin
          ok_d    = 1'b0;
          ptime_d = '0;
          pkind_d = '0;
          case (cmd_i)
            CMD_ADD: begin
              new_d.ev_time = event_time_i;
              new_d.kind    = event_kind_i;
              idx_d         = count_q;
              // Fetch the last held entry to start the search from the tail.
              if (count_q != DepthC && count_q != '0) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = cnt_m1[AddrW-1:0];
              end
            end
            CMD_POP: begin
              if (due) begin
                ok_d    = 1'b1;
                ptime_d = head_q.ev_time;
                pkind_d = head_q.kind;
                if (count_q == OneC) begin
                  count_d = '0;
                end else begin
                  idx_d       = OneC;
                  mem_re_o    = 1'b1;
                  mem_raddr_o = OneC[AddrW-1:0];
                end
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              ok_d    = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_ADD_CMP: begin
        // A later entry moves up one place; fetch the one below it.
        if (cmp_gt) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q[AddrW-1:0];
          mem_wdata_o = mem_rdata_i;
          idx_d       = idx_m1;
          if (idx_q != OneC) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_m2[AddrW-1:0];
          end
        end
      end
      ST_ADD_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AddrW-1:0];
        mem_wdata_o = new_q;
        count_d     = count_q + OneC;
        ok_d        = 1'b1;
        if (idx_q == '0) begin
          head_d = new_q;
        end
      end
      ST_POP_MV: begin
        // Each entry moves down one place; the first one becomes the head.
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_m1[AddrW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (idx_q == OneC) begin
          head_d = mem_rdata_i;
        end
        if (idx_p1 < count_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_p1[AddrW-1:0];
          idx_d       = idx_p1;
        end else begin
          count_d = cnt_m1;
        end
      end
      default: begin
        idx_d = idx_q;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ok_q    <= ok_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    new_q   <= new_d;
    ptime_q <= ptime_d;
    pkind_q <= pkind_d;
  end

  // Result and handshake outputs.
  assign busy           = (state_q != ST_IDLE) && (state_q != ST_DONE);
  assign result_valid_o = (state_q == ST_DONE);
  assign count_wide     = {{CountW{1'b0}}, count_q};
  assign op_ok_o        = ok_q;
  assign popped_time_o  = ptime_q;
  assign popped_kind_o  = pkind_q;
  assign entry_count_o  = count_wide[CountW-1:0];
  assign head_valid_o   = (count_q != '0);
  assign head_time_o    = (count_q != '0) ? head_q.ev_time : '0;

`ifndef ASSERT_OFF
  // The fill count never exceeds the storage depth.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("queue count exceeds depth");

  // The insertion search always has an entry below the gap to look at.
  a_add_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_CMP) |-> (idx_q != '0) && (idx_q <= count_q))
    else $error("insertion index out of range");

  // The pop walk only moves held entries.
  a_pop_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP_MV) |-> (idx_q != '0) && (idx_q < count_q))
    else $error("pop index out of range");

  // A finished add leaves exactly one more entry than before.
  a_add_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD_PUT) |=> (count_q == $past(count_q) + OneC))
    else $error("add did not grow the queue by one");

  // A pop that reports success always comes from a held entry.
  a_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == CMD_POP && count_q == '0) |=> !ok_q)
    else $error("pop succeeded on an empty queue");
`endif

endmodule : taq_seq

@@ rtl/timed_action_sorted_queue.sv @@
// ----------------------------------------------------------------------------
// timed_action_sorted_queue
// Bounded queue of timed actions kept in ascending time order.
// ----------------------------------------------------------------------------
// Usage: drive cmd_i and its operands with start high; the item is taken at
// the rising edge where start is high and busy is low. Commands are add
// (insert after all entries of equal time, refused when full), pop due
// (remove the head when its time is at or before now_time_i) and clear.
// Each item gives one result, shown for exactly one cycle with
// result_valid_o high; it also reports the count and head after the command.
// An add walks the entries behind the insertion point, moving each up one
// place, then writes the new action; a due pop moves every remaining entry
// down one place to close the gap. A refused add, a pop with nothing due,
// clear and the unused code go straight to the result. The walk through the
// entry storage, with one read and one write port, moves one entry a cycle.
// busy is low again in the result cycle, so the next item may be taken then.
// Reset empties the queue at once; entry storage needs no clearing pass.
// The receiver cannot stall: a result must be taken in its cycle.
// ----------------------------------------------------------------------------
module timed_action_sorted_queue #(
  parameter int unsigned QueueDepth = taq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [taq_pkg::CmdW-1:0]    cmd_i,
  input  logic [taq_pkg::TimeW-1:0]   event_time_i,
  input  logic [taq_pkg::KindW-1:0]   event_kind_i,
  input  logic [taq_pkg::TimeW-1:0]   now_time_i,
  output logic                        result_valid_o,
  output logic                        op_ok_o,
  output logic [taq_pkg::TimeW-1:0]   popped_time_o,
  output logic [taq_pkg::KindW-1:0]   popped_kind_o,
  output logic [taq_pkg::CountW-1:0]  entry_count_o,
  output logic                        head_valid_o,
  output logic [taq_pkg::TimeW-1:0]   head_time_o
);
  import taq_pkg::*;

  localparam int unsigned AddrW = $clog2(QueueDepth);
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;
  entry_t           mem_rdata;

  // Command sequencer with the shared comparator.
  taq_seq #(
    .Depth (QueueDepth),
    .AddrW (AddrW),
    .CntW  (CntW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .event_time_i   (event_time_i),
    .event_kind_i   (event_kind_i),
    .now_time_i     (now_time_i),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .result_valid_o (result_valid_o),
    .op_ok_o        (op_ok_o),
    .popped_time_o  (popped_time_o),
    .popped_kind_o  (popped_kind_o),
    .entry_count_o  (entry_count_o),
    .head_valid_o   (head_valid_o),
    .head_time_o    (head_time_o)
  );

  // Entry storage.
  taq_store #(
    .Depth (QueueDepth),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule : timed_action_sorted_queue

@@ sim/taq_checker.sv @@
// ----------------------------------------------------------------------------
// taq_checker
// Watches the command and result ports of the timed action sorted queue. It
// keeps its own sorted copy of the held actions, predicts the result of every
// accepted item and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module taq_checker #(
  parameter int unsigned QueueDepth = taq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [taq_pkg::CmdW-1:0]    cmd_i,
  input  logic [taq_pkg::TimeW-1:0]   event_time_i,
  input  logic [taq_pkg::KindW-1:0]   event_kind_i,
  input  logic [taq_pkg::TimeW-1:0]   now_time_i,
  input  logic                        result_valid_i,
  input  logic                        op_ok_i,
  input  logic [taq_pkg::TimeW-1:0]   popped_time_i,
  input  logic [taq_pkg::KindW-1:0]   popped_kind_i,
  input  logic [taq_pkg::CountW-1:0]  entry_count_i,
  input  logic                        head_valid_i,
  input  logic [taq_pkg::TimeW-1:0]   head_time_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          due_pops_o,
  output int                          refused_adds_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import taq_pkg::*;

  localparam int unsigned ReportLimit = 10;

  // One predicted result of a command.
  typedef struct packed {
    logic              op_ok;
    logic [TimeW-1:0]  popped_time;
    logic [KindW-1:0]  popped_kind;
    logic [CountW-1:0] entry_count;
    logic              head_valid;
    logic [TimeW-1:0]  head_time;
  } outcome_t;

  // Shadow copy of the queue contents, kept in ascending time order.
  logic [TimeW-1:0] shadow_times [QueueDepth];
  logic [KindW-1:0] shadow_kinds [QueueDepth];
  int unsigned      shadow_count;

  outcome_t pending_outcomes [$];

  initial begin
    fail_count_o   = 0;
    pending_o      = 0;
    checked_o      = 0;
    due_pops_o     = 0;
    refused_adds_o = 0;
    shadow_count   = 0;
  end

  // Apply one command to the shadow queue and return what the block should report.
  function automatic outcome_t apply_command(logic [CmdW-1:0] cmd,
                                             logic [TimeW-1:0] ev_time,
                                             logic [KindW-1:0] ev_kind,
                                             logic [TimeW-1:0] now);
    outcome_t res;
    int       slot;
    res = '0;
    case (cmd)
      CMD_ADD: begin
        // Insert behind every held action of equal time; refused when full.
        if (shadow_count < QueueDepth) begin
          slot = shadow_count;
          while (slot > 0 && shadow_times[slot-1] > ev_time) begin
            shadow_times[slot] = shadow_times[slot-1];
            shadow_kinds[slot] = shadow_kinds[slot-1];
            slot--;
          end
          shadow_times[slot] = ev_time;
          shadow_kinds[slot] = ev_kind;
          shadow_count++;
          res.op_ok = 1'b1;
        end
      end
      CMD_POP: begin
        // The head leaves only once its time has come.
        if (shadow_count > 0 && shadow_times[0] <= now) begin
          res.popped_time = shadow_times[0];
          res.popped_kind = shadow_kinds[0];
          for (int i = 1; i < shadow_count; i++) begin
            shadow_times[i-1] = shadow_times[i];
            shadow_kinds[i-1] = shadow_kinds[i];
          end
          shadow_count--;
          res.op_ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        res.op_ok    = 1'b1;
      end
      default: begin
        // The unused code leaves everything as it is.
      end
    endcase
    res.entry_count = shadow_count[CountW-1:0];
    res.head_valid  = (shadow_count > 0);
    res.head_time   = (shadow_count > 0) ? shadow_times[0] : '0;
    return res;
  endfunction

  // Compare one result field and report the first few differences.
  task automatic check_field(string name, logic [TimeW-1:0] want, logic [TimeW-1:0] got);
    if (want !== got) begin
      fail_count_o++;
      if (fail_count_o <= ReportLimit) begin
        $display("taq_checker: %0t ns: %s expected 0x%0h, got 0x%0h",
                 $time, name, want, got);
      end
    end
  endtask

  // Results are matched first, since an item taken at the same edge is newer.
  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    outcome_t pred;
    if (!rst_ni) begin
      shadow_count = 0;
      pending_outcomes.delete();
      pending_o = 0;
    end else begin
      if (result_valid_i) begin
        if (pending_outcomes.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit) begin
            $display("taq_checker: %0t ns: result with no item outstanding", $time);
          end
        end else begin
          want = pending_outcomes.pop_front();
          checked_o++;
          check_field("op_ok",       TimeW'(want.op_ok),       TimeW'(op_ok_i));
          check_field("popped_time", want.popped_time,         popped_time_i);
          check_field("popped_kind", TimeW'(want.popped_kind), TimeW'(popped_kind_i));
          check_field("entry_count", TimeW'(want.entry_count), TimeW'(entry_count_i));
          check_field("head_valid",  TimeW'(want.head_valid),  TimeW'(head_valid_i));
          check_field("head_time",   want.head_time,           head_time_i);
        end
      end
      if (start_i && !busy_i) begin
        pred = apply_command(cmd_i, event_time_i, event_kind_i, now_time_i);
        if (cmd_i == CMD_POP && pred.op_ok) due_pops_o++;
        if (cmd_i == CMD_ADD && !pred.op_ok) refused_adds_o++;
        pending_outcomes.push_back(pred);
      end
      pending_o = pending_outcomes.size();
    end
  end

endmodule : taq_checker

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives commands into the timed action sorted queue: a directed opening that
// covers ordering of equal times, due and not-due pops, a full queue and the
// unused code, then random fill and drain phases with idle gaps. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import taq_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED   = 2'd3;
  localparam int unsigned     RandomItems  = 800;
  localparam int unsigned     WatchdogMax  = 2000;
  localparam int unsigned     DrainCycles  = QUEUE_DEPTH_DEF + 8;
  localparam logic [TimeW-1:0] TimeMax     = '1;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [CmdW-1:0]    cmd_drv;
  logic [TimeW-1:0]   event_time_drv;
  logic [KindW-1:0]   event_kind_drv;
  logic [TimeW-1:0]   now_time_drv;
  logic               result_valid;
  logic               op_ok;
  logic [TimeW-1:0]   popped_time;
  logic [KindW-1:0]   popped_kind;
  logic [CountW-1:0]  entry_count;
  logic               head_valid;
  logic [TimeW-1:0]   head_time;

  int fail_count;
  int pending;
  int checked;
  int due_pops;
  int refused_adds;

  int  adds_sent;
  int  pops_sent;
  int  clears_sent;
  int  unused_sent;
  int  stall_cycles;
  logic steady_burst;

  timed_action_sorted_queue #(
    .QueueDepth(QUEUE_DEPTH_DEF)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_drv),
    .event_time_i   (event_time_drv),
    .event_kind_i   (event_kind_drv),
    .now_time_i     (now_time_drv),
    .result_valid_o (result_valid),
    .op_ok_o        (op_ok),
    .popped_time_o  (popped_time),
    .popped_kind_o  (popped_kind),
    .entry_count_o  (entry_count),
    .head_valid_o   (head_valid),
    .head_time_o    (head_time)
  );

  taq_checker #(
    .QueueDepth(QUEUE_DEPTH_DEF)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_drv),
    .event_time_i   (event_time_drv),
    .event_kind_i   (event_kind_drv),
    .now_time_i     (now_time_drv),
    .result_valid_i (result_valid),
    .op_ok_i        (op_ok),
    .popped_time_i  (popped_time),
    .popped_kind_i  (popped_kind),
    .entry_count_i  (entry_count),
    .head_valid_i   (head_valid),
    .head_time_i    (head_time),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .due_pops_o     (due_pops),
    .refused_adds_o (refused_adds)
  );

  // 4 ns clock.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog: ends the run when nothing moves for too long.
  initial stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WatchdogMax) begin
      $display("tb_top: no item accepted for %0d cycles", WatchdogMax);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Present one command and hold it until the block takes it, then maybe idle.
  task automatic issue_item(logic [CmdW-1:0] cmd, logic [TimeW-1:0] ev_time,
                            logic [KindW-1:0] ev_kind, logic [TimeW-1:0] now);
    @(negedge clk_i);
    start          <= 1'b1;
    cmd_drv        <= cmd;
    event_time_drv <= ev_time;
    event_kind_drv <= ev_kind;
    now_time_drv   <= now;
    case (cmd)
      CMD_ADD:   adds_sent++;
      CMD_POP:   pops_sent++;
      CMD_CLEAR: clears_sent++;
      default:   unused_sent++;
    endcase
    do @(posedge clk_i); while (busy);
    if (!steady_burst && $urandom_range(99) < 19) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(19)) @(negedge clk_i);
    end
  endtask

  // Mostly times close to a slowly advancing clock so that ties and due
  // checks happen often; the rest are extremes or fully random.
  function automatic logic [TimeW-1:0] pick_time(logic [TimeW-1:0] base);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return base + TimeW'($urandom_range(40));
    if (roll < 85) return TimeW'($urandom);
    if (roll < 92) return '0;
    return TimeMax;
  endfunction

  // Stimulus.
  initial begin
    int unsigned      roll;
    logic [CmdW-1:0]  cmd_pick;
    logic [TimeW-1:0] clock_base;
    logic             filling;
    rst_ni         = 1'b0;
    start          = 1'b0;
    cmd_drv        = CMD_ADD;
    event_time_drv = '0;
    event_kind_drv = '0;
    now_time_drv   = '0;
    steady_burst   = 1'b0;
    adds_sent      = 0;
    pops_sent      = 0;
    clears_sent    = 0;
    unused_sent    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pop from an empty queue.
    issue_item(CMD_POP, '0, '0, TimeMax);
    // Equal times keep arrival order; kind 3 is stored as given.
    issue_item(CMD_ADD, 32'd100, 2'd0, '0);
    issue_item(CMD_ADD, 32'd100, 2'd1, '0);
    issue_item(CMD_ADD, 32'd50,  2'd2, '0);
    issue_item(CMD_ADD, 32'd0,   2'd3, '0);
    issue_item(CMD_ADD, TimeMax, 2'd1, '0);
    // Due exactly at its time, then not yet due, then due.
    issue_item(CMD_POP, '0, '0, 32'd0);
    issue_item(CMD_POP, '0, '0, 32'd49);
    issue_item(CMD_POP, TimeMax, 2'd3, 32'd50);
    // The unused code changes nothing.
    issue_item(CMD_UNUSED, TimeMax, 2'd3, TimeMax);
    // Fill to the top with descending times, one tie among them.
    for (int i = 0; i < 13; i++) begin
      issue_item(CMD_ADD, (i == 6) ? 32'd100 : 32'd2000 - 32'(i) * 32'd150,
                 KindW'(i), '0);
    end
    // Add on a full queue is refused; then pop and clear.
    issue_item(CMD_ADD, 32'd1, 2'd2, '0);
    issue_item(CMD_POP, '0, '0, TimeMax);
    issue_item(CMD_CLEAR, '0, '0, '0);

    // Random: alternate fill-biased and drain-biased stretches.
    clock_base = $urandom;
    for (int n = 0; n < RandomItems; n++) begin
      filling      = ((n / 60) % 2 == 0);
      steady_burst = (n >= 300 && n < 500);
      roll         = $urandom_range(99);
      if (roll < 3) cmd_pick = CMD_CLEAR;
      else if (roll < 5) cmd_pick = CMD_UNUSED;
      else if (roll < (filling ? 72 : 32)) cmd_pick = CMD_ADD;
      else cmd_pick = CMD_POP;
      clock_base += TimeW'($urandom_range(3));
      issue_item(cmd_pick, pick_time(clock_base), KindW'($urandom_range(3)),
                 pick_time(clock_base));
    end

    // Drain: wait for every outstanding result, then a little longer.
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("tb_top: %0d commands sent: %0d add, %0d pop-due, %0d clear, %0d unused code",
             adds_sent + pops_sent + clears_sent + unused_sent,
             adds_sent, pops_sent, clears_sent, unused_sent);
    $display("tb_top: %0d results checked, %0d due pops, %0d adds refused when full, %0d mismatches",
             checked, due_pops, refused_adds, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule : tb_top
